// ----- src/gkcd_pkg.sv -----
// ----------------------------------------------------------------------------
// gkcd_pkg
// Shared types and constants of the k-core decomposition engine: request and
// response payloads, opcodes, status codes, sequencer steps, command/status.
// ----------------------------------------------------------------------------
package gkcd_pkg;

   localparam int DEF_MAX_VERTICES    = 1024;
   localparam int DEF_MAX_ADJ_ENTRIES = 8192;
   localparam int VERTEX_W            = 10;
   localparam int CORE_W              = 10;
   localparam int CSR_W               = 11;
   localparam int CORE_MAX            = 1023;
   localparam int NUM_STEPS           = 34;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_RUN   = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_ORDER     = 2'd2,
      ST_NOT_READY = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [VERTEX_W-1:0] vertex;
      logic [VERTEX_W-1:0] neighbor;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex_echo;
      logic [CORE_W-1:0]   core_number;
      status_type          status;
   } rsp_type;

   typedef enum logic [NUM_STEPS-1:0] {
      S_IDLE      = 34'd1 << 0,
      S_DECODE    = 34'd1 << 1,
      S_READ_RESP = 34'd1 << 2,
      S_DUP_RD    = 34'd1 << 3,
      S_DUP_CMP   = 34'd1 << 4,
      S_ADD_CHK   = 34'd1 << 5,
      S_ADD_FILL  = 34'd1 << 6,
      S_RUN_FILL  = 34'd1 << 7,
      S_DEG_V     = 34'd1 << 8,
      S_DEG_END   = 34'd1 << 9,
      S_DEG_E     = 34'd1 << 10,
      S_DEG_CNT   = 34'd1 << 11,
      S_BIN_CLR   = 34'd1 << 12,
      S_CNT_RD    = 34'd1 << 13,
      S_CNT_BIN   = 34'd1 << 14,
      S_CNT_WR    = 34'd1 << 15,
      S_PRE_RD    = 34'd1 << 16,
      S_PRE_WR    = 34'd1 << 17,
      S_POS_RD    = 34'd1 << 18,
      S_POS_BIN   = 34'd1 << 19,
      S_POS_WR    = 34'd1 << 20,
      S_SH_RD     = 34'd1 << 21,
      S_SH_WR     = 34'd1 << 22,
      S_PEEL_I    = 34'd1 << 23,
      S_PEEL_V    = 34'd1 << 24,
      S_PEEL_S0   = 34'd1 << 25,
      S_PEEL_S1   = 34'd1 << 26,
      S_PEEL_DV   = 34'd1 << 27,
      S_PEEL_E    = 34'd1 << 28,
      S_PEEL_U    = 34'd1 << 29,
      S_PEEL_DU   = 34'd1 << 30,
      S_PEEL_PB   = 34'd1 << 31,
      S_PEEL_W    = 34'd1 << 32,
      S_PEEL_SW   = 34'd1 << 33
   } step_type;

   typedef struct packed {
      step_type   step;
      logic       load;
      logic       rsp_en;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       bad_entry;
      logic       v_eq_last;
      logic       rd_bad;
      logic       ready;
      logic       full;
      logic       e_ge_entries;
      logic       dup_hit;
      logic       k_le_v;
      logic       k_le_n;
      logic       v_eq_n;
      logic       e_ge_end;
      logic       i_le_md;
      logic       i_zero;
      logic       i_eq_n;
      logic       adj_ge_n;
      logic       deg_gt_dv;
      logic       sorted_ne_u;
   } sts_type;

endpackage

// ----- src/gkcd_ram.sv -----
// ----------------------------------------------------------------------------
// gkcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gkcd_ram #(
   parameter int WIDTH  = 10,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/gkcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// gkcd_ctrl
// Sequencer: decodes each request and steps the datapath through loading,
// degree count, bin sort and peeling.
// ----------------------------------------------------------------------------
module gkcd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gkcd_pkg::sts_type sts,
   output gkcd_pkg::cmd_type cmd
);
   import gkcd_pkg::*;

   step_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.step       = state_ff;
      cmd.load       = 1'b0;
      cmd.rsp_en     = 1'b0;
      cmd.rsp_status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.opcode)
               OP_CLEAR: begin
                  cmd.rsp_en = 1'b1;
                  state_in   = S_IDLE;
               end
               OP_ADD: begin
                  if (sts.bad_entry) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_ORDER;
                     state_in       = S_IDLE;
                  end else if (sts.v_eq_last) begin
                     state_in = S_DUP_RD;
                  end else begin
                     state_in = S_ADD_CHK;
                  end
               end
               OP_RUN: state_in = S_RUN_FILL;
               OP_READ: begin
                  if (!sts.ready) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_NOT_READY;
                     state_in       = S_IDLE;
                  end else if (sts.rd_bad) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_ORDER;
                     state_in       = S_IDLE;
                  end else begin
                     state_in = S_READ_RESP;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_READ_RESP: begin
            cmd.rsp_en = 1'b1;
            state_in   = S_IDLE;
         end
         S_DUP_RD: state_in = sts.e_ge_entries ? S_ADD_CHK : S_DUP_CMP;
         S_DUP_CMP: begin
            if (sts.dup_hit) begin
               cmd.rsp_en = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_DUP_RD;
            end
         end
         S_ADD_CHK: begin
            if (sts.full) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_FULL;
               state_in       = S_IDLE;
            end else begin
               state_in = S_ADD_FILL;
            end
         end
         S_ADD_FILL: begin
            if (!sts.k_le_v) begin
               cmd.rsp_en = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_RUN_FILL: if (!sts.k_le_n) state_in = S_DEG_V;
         S_DEG_V:    state_in = sts.v_eq_n ? S_BIN_CLR : S_DEG_END;
         S_DEG_END:  state_in = S_DEG_E;
         S_DEG_E:    state_in = sts.e_ge_end ? S_DEG_V : S_DEG_CNT;
         S_DEG_CNT:  state_in = S_DEG_E;
         S_BIN_CLR:  if (!sts.i_le_md) state_in = S_CNT_RD;
         S_CNT_RD:   state_in = sts.v_eq_n ? S_PRE_RD : S_CNT_BIN;
         S_CNT_BIN:  state_in = S_CNT_WR;
         S_CNT_WR:   state_in = S_CNT_RD;
         S_PRE_RD:   state_in = sts.i_le_md ? S_PRE_WR : S_POS_RD;
         S_PRE_WR:   state_in = S_PRE_RD;
         S_POS_RD:   state_in = sts.v_eq_n ? S_SH_RD : S_POS_BIN;
         S_POS_BIN:  state_in = S_POS_WR;
         S_POS_WR:   state_in = S_POS_RD;
         S_SH_RD:    state_in = sts.i_zero ? S_PEEL_I : S_SH_WR;
         S_SH_WR:    state_in = S_SH_RD;
         S_PEEL_I: begin
            if (sts.i_eq_n) begin
               cmd.rsp_en = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_PEEL_V;
            end
         end
         S_PEEL_V:  state_in = S_PEEL_S0;
         S_PEEL_S0: state_in = S_PEEL_S1;
         S_PEEL_S1: state_in = S_PEEL_DV;
         S_PEEL_DV: state_in = S_PEEL_E;
         S_PEEL_E:  state_in = sts.e_ge_end ? S_PEEL_I : S_PEEL_U;
         S_PEEL_U:  state_in = sts.adj_ge_n ? S_PEEL_E : S_PEEL_DU;
         S_PEEL_DU: state_in = sts.deg_gt_dv ? S_PEEL_PB : S_PEEL_E;
         S_PEEL_PB: state_in = S_PEEL_W;
         S_PEEL_W:  state_in = sts.sorted_ne_u ? S_PEEL_SW : S_PEEL_E;
         S_PEEL_SW: state_in = S_PEEL_E;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- src/gkcd_dp.sv -----
// ----------------------------------------------------------------------------
// gkcd_dp
// Datapath: graph and peeling tables, counters, flags and response register.
// ----------------------------------------------------------------------------
module gkcd_dp #(
   parameter int MAX_VERTICES    = 1024,
   parameter int MAX_ADJ_ENTRIES = 8192
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gkcd_pkg::req_type               req_data,
   input  logic                            csr_wr_en,
   input  logic [gkcd_pkg::CSR_W-1:0]      csr_wr_data,
   input  gkcd_pkg::cmd_type               cmd,
   output gkcd_pkg::sts_type               sts,
   output logic                            rsp_valid,
   output gkcd_pkg::rsp_type               rsp_data
);
   import gkcd_pkg::*;

   localparam int VIW = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int AW  = $clog2(MAX_ADJ_ENTRIES);
   localparam int EW  = $clog2(MAX_ADJ_ENTRIES + 1);

   logic [CW-1:0]  vcount_ff, vcount_in;
   logic [EW-1:0]  entries_ff, entries_in;
   logic [VIW-1:0] last_ff, last_in;
   logic [EW-1:0]  cur_start_ff, cur_start_in;
   logic           ready_ff, ready_in;
   req_type        req_ff, req_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [EW-1:0]  e_ff, e_in;
   logic [EW-1:0]  e_end_ff, e_end_in;
   logic [CW-1:0]  v_ff, v_in;
   logic [CW-1:0]  i_ff, i_in;
   logic [CW-1:0]  md_ff, md_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  acc_ff, acc_in;
   logic [CW-1:0]  du_ff, du_in;
   logic [CW-1:0]  dv_ff, dv_in;
   logic [VIW-1:0] u_ff, u_in;
   logic [VIW-1:0] pu_ff, pu_in;
   logic [CW-1:0]  pw_ff, pw_in;
   logic [VIW-1:0] w_ff, w_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff;

   // table ports
   logic           adj_we;
   logic [AW-1:0]  adj_wa, adj_ra;
   logic [VIW-1:0] adj_wd, adj_rd;
   logic           st_we;
   logic [CW-1:0]  st_wa, st_ra;
   logic [EW-1:0]  st_wd, st_rd;
   logic           deg_we;
   logic [VIW-1:0] deg_wa, deg_ra;
   logic [CW-1:0]  deg_wd, deg_rd;
   logic           pos_we;
   logic [VIW-1:0] pos_wa, pos_ra;
   logic [VIW-1:0] pos_wd, pos_rd;
   logic           so_we;
   logic [VIW-1:0] so_wa, so_ra;
   logic [VIW-1:0] so_wd, so_rd;
   logic           bin_we;
   logic [CW-1:0]  bin_wa, bin_ra;
   logic [CW-1:0]  bin_wd, bin_rd;

   logic [31:0]    n32;
   logic [31:0]    csr32;

   gkcd_ram #(.WIDTH(VIW), .DEPTH(MAX_ADJ_ENTRIES), .ADDR_W(AW)) u_adj (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
      .rd_addr(adj_ra), .rd_data(adj_rd));
   gkcd_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES + 1), .ADDR_W(CW)) u_start (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));
   gkcd_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES), .ADDR_W(VIW)) u_deg (
      .clock(clock), .wr_en(deg_we), .wr_addr(deg_wa), .wr_data(deg_wd),
      .rd_addr(deg_ra), .rd_data(deg_rd));
   gkcd_ram #(.WIDTH(VIW), .DEPTH(MAX_VERTICES), .ADDR_W(VIW)) u_pos (
      .clock(clock), .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(pos_wd),
      .rd_addr(pos_ra), .rd_data(pos_rd));
   gkcd_ram #(.WIDTH(VIW), .DEPTH(MAX_VERTICES), .ADDR_W(VIW)) u_sorted (
      .clock(clock), .wr_en(so_we), .wr_addr(so_wa), .wr_data(so_wd),
      .rd_addr(so_ra), .rd_data(so_rd));
   gkcd_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES + 1), .ADDR_W(CW)) u_bin (
      .clock(clock), .wr_en(bin_we), .wr_addr(bin_wa), .wr_data(bin_wd),
      .rd_addr(bin_ra), .rd_data(bin_rd));

   assign n32   = 32'(vcount_ff);
   assign csr32 = 32'(csr_wr_data);

   always_comb begin
      sts.opcode       = req_ff.opcode;
      sts.bad_entry    = (32'(req_ff.vertex) < 32'(last_ff)) ||
                         (32'(req_ff.vertex) >= n32) || (32'(req_ff.neighbor) >= n32);
      sts.v_eq_last    = (32'(req_ff.vertex) == 32'(last_ff));
      sts.rd_bad       = (32'(req_ff.vertex) >= n32);
      sts.ready        = ready_ff;
      sts.full         = (32'(entries_ff) >= MAX_ADJ_ENTRIES);
      sts.e_ge_entries = (e_ff >= entries_ff);
      sts.dup_hit      = (32'(adj_rd) == 32'(req_ff.neighbor));
      sts.k_le_v       = (32'(k_ff) <= 32'(req_ff.vertex));
      sts.k_le_n       = (k_ff <= vcount_ff);
      sts.v_eq_n       = (v_ff == vcount_ff);
      sts.e_ge_end     = (e_ff >= e_end_ff);
      sts.i_le_md      = (i_ff <= md_ff);
      sts.i_zero       = (i_ff == '0);
      sts.i_eq_n       = (i_ff == vcount_ff);
      sts.adj_ge_n     = (32'(adj_rd) >= n32);
      sts.deg_gt_dv    = (deg_rd > dv_ff);
      sts.sorted_ne_u  = (so_rd != u_ff);
   end

   always_comb begin
      vcount_in    = vcount_ff;
      entries_in   = entries_ff;
      last_in      = last_ff;
      cur_start_in = cur_start_ff;
      ready_in     = ready_ff;
      req_in       = req_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      e_end_in     = e_end_ff;
      v_in         = v_ff;
      i_in         = i_ff;
      md_in        = md_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      du_in        = du_ff;
      dv_in        = dv_ff;
      u_in         = u_ff;
      pu_in        = pu_ff;
      pw_in        = pw_ff;
      w_in         = w_ff;
      rsp_in       = rsp_ff;
      adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_ra = '0;
      st_we  = 1'b0; st_wa  = '0; st_wd  = '0; st_ra  = '0;
      deg_we = 1'b0; deg_wa = '0; deg_wd = '0; deg_ra = '0;
      pos_we = 1'b0; pos_wa = '0; pos_wd = '0; pos_ra = '0;
      so_we  = 1'b0; so_wa  = '0; so_wd  = '0; so_ra  = '0;
      bin_we = 1'b0; bin_wa = '0; bin_wd = '0; bin_ra = '0;

      case (cmd.step)
         S_IDLE: begin
            if (cmd.load) req_in = req_data;
         end
         S_DECODE: begin
            e_in   = cur_start_ff;
            k_in   = CW'(last_ff) + 1'b1;
            deg_ra = VIW'(req_ff.vertex);
            if (req_ff.opcode == OP_CLEAR) begin
               entries_in   = '0;
               last_in      = '0;
               cur_start_in = '0;
               ready_in     = 1'b0;
            end
         end
         S_DUP_RD:  adj_ra = e_ff[AW-1:0];
         S_DUP_CMP: e_in = e_ff + 1'b1;
         S_ADD_FILL: begin
            if (sts.k_le_v) begin
               st_we = 1'b1;
               st_wa = k_ff;
               st_wd = entries_ff;
               k_in  = k_ff + 1'b1;
            end else begin
               adj_we     = 1'b1;
               adj_wa     = entries_ff[AW-1:0];
               adj_wd     = VIW'(req_ff.neighbor);
               entries_in = entries_ff + 1'b1;
               last_in    = VIW'(req_ff.vertex);
               ready_in   = 1'b0;
               if (!sts.v_eq_last) cur_start_in = entries_ff;
            end
         end
         S_RUN_FILL: begin
            if (sts.k_le_n) begin
               st_we = 1'b1;
               st_wa = k_ff;
               st_wd = entries_ff;
               k_in  = k_ff + 1'b1;
            end else begin
               // vertex zero always starts at the first entry
               st_we = 1'b1;
               v_in  = '0;
               e_in  = '0;
               md_in = '0;
            end
         end
         S_DEG_V: begin
            if (sts.v_eq_n) i_in = '0;
            else st_ra = v_ff + 1'b1;
         end
         S_DEG_END: begin
            e_end_in = st_rd;
            cnt_in   = '0;
         end
         S_DEG_E: begin
            if (sts.e_ge_end) begin
               deg_we = 1'b1;
               deg_wa = VIW'(v_ff);
               deg_wd = cnt_ff;
               if (cnt_ff > md_ff) md_in = cnt_ff;
               v_in = v_ff + 1'b1;
            end else begin
               adj_ra = e_ff[AW-1:0];
            end
         end
         S_DEG_CNT: begin
            // skip neighbors beyond the current vertex count
            if (!sts.adj_ge_n) cnt_in = cnt_ff + 1'b1;
            e_in = e_ff + 1'b1;
         end
         S_BIN_CLR: begin
            if (sts.i_le_md) begin
               bin_we = 1'b1;
               bin_wa = i_ff;
               i_in   = i_ff + 1'b1;
            end else begin
               v_in = '0;
            end
         end
         S_CNT_RD: begin
            if (sts.v_eq_n) begin
               i_in   = '0;
               acc_in = '0;
            end else begin
               deg_ra = VIW'(v_ff);
            end
         end
         S_CNT_BIN, S_POS_BIN: begin
            du_in  = deg_rd;
            bin_ra = deg_rd;
         end
         S_CNT_WR: begin
            bin_we = 1'b1;
            bin_wa = du_ff;
            bin_wd = bin_rd + 1'b1;
            v_in   = v_ff + 1'b1;
         end
         S_PRE_RD: begin
            if (sts.i_le_md) bin_ra = i_ff;
            else v_in = '0;
         end
         S_PRE_WR: begin
            bin_we = 1'b1;
            bin_wa = i_ff;
            bin_wd = acc_ff;
            acc_in = acc_ff + bin_rd;
            i_in   = i_ff + 1'b1;
         end
         S_POS_RD: begin
            if (sts.v_eq_n) i_in = md_ff;
            else deg_ra = VIW'(v_ff);
         end
         S_POS_WR: begin
            pos_we = 1'b1;
            pos_wa = VIW'(v_ff);
            pos_wd = VIW'(bin_rd);
            so_we  = 1'b1;
            so_wa  = VIW'(bin_rd);
            so_wd  = VIW'(v_ff);
            bin_we = 1'b1;
            bin_wa = du_ff;
            bin_wd = bin_rd + 1'b1;
            v_in   = v_ff + 1'b1;
         end
         S_SH_RD: begin
            // bin starts move up one slot; the lowest bin starts at zero
            if (sts.i_zero) bin_we = 1'b1;
            else bin_ra = i_ff - 1'b1;
         end
         S_SH_WR: begin
            bin_we = 1'b1;
            bin_wa = i_ff;
            bin_wd = bin_rd;
            i_in   = i_ff - 1'b1;
         end
         S_PEEL_I: begin
            if (sts.i_eq_n) ready_in = 1'b1;
            else so_ra = VIW'(i_ff);
         end
         S_PEEL_V: begin
            v_in  = CW'(so_rd);
            st_ra = CW'(so_rd);
         end
         S_PEEL_S0: begin
            e_in  = st_rd;
            st_ra = v_ff + 1'b1;
         end
         S_PEEL_S1: begin
            e_end_in = st_rd;
            deg_ra   = VIW'(v_ff);
         end
         S_PEEL_DV: dv_in = deg_rd;
         S_PEEL_E: begin
            if (sts.e_ge_end) i_in = i_ff + 1'b1;
            else adj_ra = e_ff[AW-1:0];
         end
         S_PEEL_U: begin
            u_in   = adj_rd;
            deg_ra = adj_rd;
            if (sts.adj_ge_n) e_in = e_ff + 1'b1;
         end
         S_PEEL_DU: begin
            du_in = deg_rd;
            if (sts.deg_gt_dv) begin
               pos_ra = u_ff;
               bin_ra = deg_rd;
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         S_PEEL_PB: begin
            pu_in = pos_rd;
            pw_in = bin_rd;
            so_ra = VIW'(bin_rd);
         end
         S_PEEL_W: begin
            w_in   = so_rd;
            bin_we = 1'b1;
            bin_wa = du_ff;
            bin_wd = pw_ff + 1'b1;
            deg_we = 1'b1;
            deg_wa = u_ff;
            deg_wd = du_ff - 1'b1;
            if (sts.sorted_ne_u) begin
               pos_we = 1'b1;
               pos_wa = u_ff;
               pos_wd = VIW'(pw_ff);
               so_we  = 1'b1;
               so_wa  = pu_ff;
               so_wd  = so_rd;
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         S_PEEL_SW: begin
            pos_we = 1'b1;
            pos_wa = w_ff;
            pos_wd = pu_ff;
            so_we  = 1'b1;
            so_wa  = VIW'(pw_ff);
            so_wd  = u_ff;
            e_in   = e_ff + 1'b1;
         end
         default: ;
      endcase

      if (cmd.rsp_en) begin
         rsp_in.vertex_echo = req_ff.vertex;
         rsp_in.status      = cmd.rsp_status;
         rsp_in.core_number = '0;
         if (cmd.step == S_READ_RESP) begin
            rsp_in.core_number = (32'(deg_rd) > CORE_MAX) ? CORE_W'(CORE_MAX)
                                                          : CORE_W'(deg_rd);
         end
      end

      if (csr_wr_en) begin
         if (csr32 == 0) vcount_in = CW'(1);
         else if (csr32 > MAX_VERTICES) vcount_in = CW'(MAX_VERTICES);
         else vcount_in = CW'(csr_wr_data);
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= CW'(1);
         entries_ff   <= '0;
         last_ff      <= '0;
         cur_start_ff <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         entries_ff   <= entries_in;
         last_ff      <= last_in;
         cur_start_ff <= cur_start_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      k_ff     <= k_in;
      e_ff     <= e_in;
      e_end_ff <= e_end_in;
      v_ff     <= v_in;
      i_ff     <= i_in;
      md_ff    <= md_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      du_ff    <= du_in;
      dv_ff    <= dv_in;
      u_ff     <= u_in;
      pu_ff    <= pu_in;
      pw_ff    <= pw_in;
      w_ff     <= w_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/graph_k_core_decomposition.sv -----
// ----------------------------------------------------------------------------
// graph_k_core_decomposition
// Loads an adjacency list, runs bin-sorted peeling and returns per-vertex
// core numbers.
//
//   channel   ports                        direction  handshake
//   request   start, busy, req_data        in         start & !busy
//   response  rsp_valid, rsp_data          out        one-cycle strobe
//   csr       csr_wr_en, csr_wr_data       in         write on enable
//
// A stored entry first scans the entries already stored for its vertex for a
// duplicate, then fills the start of each skipped vertex. Run makes a degree
// pass, a bin sort and peeling, stepping through the table memories.
// Synchronous reset; the tables need no clearing pass. The response shows for
// one cycle after busy drops and cannot be stalled.
// ----------------------------------------------------------------------------
module graph_k_core_decomposition #(
   parameter int MAX_VERTICES    = gkcd_pkg::DEF_MAX_VERTICES,
   parameter int MAX_ADJ_ENTRIES = gkcd_pkg::DEF_MAX_ADJ_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  gkcd_pkg::req_type           req_data,
   output logic                        rsp_valid,
   output gkcd_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [gkcd_pkg::CSR_W-1:0]  csr_wr_data
);
   import gkcd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gkcd_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .sts  (sts),
      .cmd  (cmd)
   );

   gkcd_dp #(
      .MAX_VERTICES   (MAX_VERTICES),
      .MAX_ADJ_ENTRIES(MAX_ADJ_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the k-core decomposition engine. A directed table
// covers reset state, field extremes, every opcode and the OK, ORDER and
// NOT_READY codes, followed by random graph phases: set the vertex count,
// clear, load symmetric adjacency lists with noise, run, read core numbers.
// Each response is checked against its typed row or a built-in peeling model.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gkcd_pkg::*;

   localparam int NV        = DEF_MAX_VERTICES;
   localparam int NE        = DEF_MAX_ADJ_ENTRIES;
   localparam int RAND_REQS = 1850;
   localparam longint CYCLE_LIMIT = 4_000_000;

   typedef enum logic { ROW_REQ, ROW_CSR } row_kind_type;
   typedef struct packed {
      row_kind_type        kind;
      opcode_type          op;
      logic [VERTEX_W-1:0] v;
      logic [VERTEX_W-1:0] nb;
      logic [CSR_W-1:0]    csr_val;
      logic                typed;
      logic [CORE_W-1:0]   core;
      status_type          st;
   } dir_row_type;

   localparam int NROWS = 27;
   dir_row_type dir_rows [NROWS] = '{
      '{ROW_REQ, OP_READ,  10'd0,    10'd0,    11'd0,    1'b1, 10'd0, ST_NOT_READY},
      '{ROW_REQ, OP_ADD,   10'd0,    10'd0,    11'd0,    1'b1, 10'd0, ST_OK},
      '{ROW_REQ, OP_ADD,   10'd0,    10'd0,    11'd0,    1'b1, 10'd0, ST_OK},
      '{ROW_REQ, OP_ADD,   10'd1023, 10'd0,    11'd0,    1'b1, 10'd0, ST_ORDER},
      '{ROW_REQ, OP_ADD,   10'd0,    10'd1023, 11'd0,    1'b1, 10'd0, ST_ORDER},
      '{ROW_REQ, OP_RUN,   10'd0,    10'd0,    11'd0,    1'b1, 10'd0, ST_OK},
      '{ROW_REQ, OP_READ,  10'd0,    10'd0,    11'd0,    1'b1, 10'd1, ST_OK},
      '{ROW_REQ, OP_READ,  10'd1023, 10'd0,    11'd0,    1'b1, 10'd0, ST_ORDER},
      '{ROW_CSR, OP_CLEAR, 10'd0,    10'd0,    11'd2047, 1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_READ,  10'd0,    10'd0,    11'd0,    1'b1, 10'd0, ST_NOT_READY},
      '{ROW_REQ, OP_CLEAR, 10'd1023, 10'd1023, 11'd0,    1'b1, 10'd0, ST_OK},
      '{ROW_REQ, OP_ADD,   10'd0,    10'd1,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_ADD,   10'd0,    10'd1023, 11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_ADD,   10'd1,    10'd0,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_ADD,   10'd1,    10'd2,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_ADD,   10'd0,    10'd2,    11'd0,    1'b1, 10'd0, ST_ORDER},
      '{ROW_REQ, OP_ADD,   10'd2,    10'd1,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_ADD,   10'd1023, 10'd0,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_ADD,   10'd1023, 10'd1023, 11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_RUN,   10'd0,    10'd0,    11'd0,    1'b1, 10'd0, ST_OK},
      '{ROW_REQ, OP_READ,  10'd0,    10'd0,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_READ,  10'd1,    10'd0,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_READ,  10'd1023, 10'd0,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_READ,  10'd512,  10'd0,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_CSR, OP_CLEAR, 10'd0,    10'd0,    11'd0,    1'b0, 10'd0, ST_OK},
      '{ROW_REQ, OP_CLEAR, 10'd0,    10'd0,    11'd0,    1'b1, 10'd0, ST_OK},
      '{ROW_REQ, OP_READ,  10'd0,    10'd0,    11'd0,    1'b1, 10'd0, ST_NOT_READY}
   };

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   graph_k_core_decomposition dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // peeling model state
   int unsigned n_vertices;
   int unsigned nb_store [NE];
   int unsigned first_entry [NV+1];
   int unsigned core_tab [NV];
   int unsigned pos_tab [NV];
   int unsigned order_tab [NV];
   int unsigned bin_tab [NV+2];
   int unsigned n_loaded;
   int unsigned last_v;
   bit          cores_valid;

   rsp_type     expected_rsps [$];
   bit          cur_typed;
   rsp_type     cur_typed_rsp;
   int          errors;
   longint      cycles;
   int          reqs_sent;
   int          runs_done;
   int          reads_ok;
   int          full_hits;
   bit          idle_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void fill_starts(int unsigned upto);
      for (int unsigned k = last_v + 1; k <= upto && k <= NV; k++)
         first_entry[k] = n_loaded;
   endfunction

   function automatic status_type add_adjacency(int unsigned v, int unsigned nb);
      if (v < last_v || v >= n_vertices || nb >= n_vertices)
         return ST_ORDER;
      if (v == last_v)
         for (int unsigned i = first_entry[v]; i < n_loaded; i++)
            if (nb_store[i] == nb)
               return ST_OK;
      if (n_loaded >= NE)
         return ST_FULL;
      fill_starts(v);
      last_v = v;
      nb_store[n_loaded] = nb;
      n_loaded++;
      cores_valid = 1'b0;
      return ST_OK;
   endfunction

   function automatic void peel_cores();
      int unsigned n, md, acc, cnt, v, u, du, pu, pw, w;
      n = n_vertices;
      md = 0;
      fill_starts(n);
      for (v = 0; v < n; v++) begin
         cnt = 0;
         for (int unsigned e = first_entry[v]; e < first_entry[v+1] && e < NE; e++)
            if (nb_store[e] < n)
               cnt++;
         core_tab[v] = cnt;
         if (cnt > md)
            md = cnt;
      end
      for (int unsigned i = 0; i <= md; i++)
         bin_tab[i] = 0;
      for (v = 0; v < n; v++)
         bin_tab[core_tab[v]]++;
      acc = 0;
      for (int unsigned i = 0; i <= md; i++) begin
         cnt = bin_tab[i];
         bin_tab[i] = acc;
         acc += cnt;
      end
      for (v = 0; v < n; v++) begin
         pos_tab[v] = bin_tab[core_tab[v]]++;
         order_tab[pos_tab[v]] = v;
      end
      for (int i = int'(md); i >= 1; i--)
         bin_tab[i] = bin_tab[i-1];
      bin_tab[0] = 0;
      for (int unsigned i = 0; i < n; i++) begin
         v = order_tab[i];
         for (int unsigned e = first_entry[v]; e < first_entry[v+1] && e < NE; e++) begin
            u = nb_store[e];
            if (u < n && core_tab[u] > core_tab[v]) begin
               du = core_tab[u];
               pu = pos_tab[u];
               pw = bin_tab[du];
               w  = order_tab[pw];
               if (u != w) begin
                  pos_tab[u] = pw;
                  order_tab[pu] = w;
                  pos_tab[w] = pu;
                  order_tab[pw] = u;
               end
               bin_tab[du]++;
               core_tab[u]--;
            end
         end
      end
      cores_valid = 1'b1;
   endfunction

   function automatic rsp_type predict_core(req_type r);
      rsp_type     p;
      int unsigned c;
      p.vertex_echo = r.vertex;
      p.core_number = '0;
      p.status      = ST_OK;
      case (r.opcode)
         OP_CLEAR: begin
            n_loaded = 0;
            last_v = 0;
            first_entry[0] = 0;
            cores_valid = 1'b0;
         end
         OP_ADD: p.status = add_adjacency(r.vertex, r.neighbor);
         OP_RUN: peel_cores();
         default: begin
            if (!cores_valid)
               p.status = ST_NOT_READY;
            else if (r.vertex >= n_vertices)
               p.status = ST_ORDER;
            else begin
               c = core_tab[r.vertex];
               p.core_number = (c > CORE_MAX) ? CORE_W'(CORE_MAX) : CORE_W'(c);
            end
         end
      endcase
      return p;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // compare first, then log the newly accepted request
   always @(posedge clock) begin
      rsp_type want, pred;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0)
               report_mismatch("unexpected response, vertex", rsp_data.vertex_echo, -1);
            else begin
               want = expected_rsps.pop_front();
               if (rsp_data.vertex_echo !== want.vertex_echo)
                  report_mismatch("vertex_echo", rsp_data.vertex_echo, want.vertex_echo);
               if (rsp_data.core_number !== want.core_number)
                  report_mismatch("core_number", rsp_data.core_number, want.core_number);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (want.status == ST_FULL)
                  full_hits++;
               if (want.status == ST_OK && rsp_data.status == ST_OK && want.core_number != 0)
                  reads_ok++;
            end
         end
         if (start && !busy) begin
            pred = predict_core(req_data);
            if (req_data.opcode == OP_RUN)
               runs_done++;
            expected_rsps.push_back(cur_typed ? cur_typed_rsp : pred);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_request(req_type r);
      if (idle_on)
         while ($urandom_range(99) < 27) begin
            start = 1'b0;
            @(negedge clock);
         end
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      @(negedge clock);
      cur_typed = 1'b0;
      reqs_sent++;
   endtask

   task automatic send_op(opcode_type op, int unsigned v, int unsigned nb);
      req_type r;
      r.opcode   = op;
      r.vertex   = VERTEX_W'(v);
      r.neighbor = VERTEX_W'(nb);
      send_request(r);
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (expected_rsps.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_vertex_count(logic [CSR_W-1:0] val);
      int unsigned s;
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = val;
      s = val;
      if (s < 1) s = 1;
      if (s > NV) s = NV;
      n_vertices  = s;
      cores_valid = 1'b0;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_request();
      req_type r;
      r.opcode   = opcode_type'($urandom_range(3));
      r.vertex   = VERTEX_W'($urandom);
      r.neighbor = VERTEX_W'($urandom);
      send_request(r);
   endtask

   // one graph phase: load symmetric lists in vertex order, run, read back
   task automatic graph_phase(int phase_no);
      int          nbrs [NV][$];
      int unsigned n, m, a, b, sel, nreads;
      logic [CSR_W-1:0] raw;
      sel = $urandom_range(99);
      if (sel < 5) begin
         case ($urandom_range(2))
            0: raw = CSR_W'(NV);
            1: raw = '1;
            default: raw = CSR_W'($urandom_range(NV + 1, 2047));
         endcase
         m = $urandom_range(0, 300);
      end else if (sel < 10) begin
         raw = CSR_W'($urandom_range(1));
         m = $urandom_range(0, 2);
      end else if (sel < 15) begin
         raw = CSR_W'($urandom_range(100, 400));
         m = $urandom_range(0, raw);
      end else begin
         raw = CSR_W'($urandom_range(2, 40));
         m = $urandom_range(0, 3 * raw);
      end
      idle_on = (phase_no % 6 != 3);
      write_vertex_count(raw);
      n = n_vertices;
      for (int unsigned i = 0; i < m; i++) begin
         a = $urandom_range(n - 1);
         b = ($urandom_range(9) == 0) ? a : $urandom_range(n - 1);
         nbrs[a].push_back(b);
         if (a != b)
            nbrs[b].push_back(a);
      end
      if ($urandom_range(9) != 0)
         send_op(OP_CLEAR, $urandom_range(NV - 1), $urandom_range(NV - 1));
      for (int unsigned v = 0; v < n; v++)
         foreach (nbrs[v][k]) begin
            send_op(OP_ADD, v, nbrs[v][k]);
            // drop in noise: stray requests, repeats and broken entries
            case ($urandom_range(49))
               0: random_request();
               1: send_op(OP_ADD, v, nbrs[v][$urandom_range(k)]);
               2: send_op(OP_ADD, $urandom_range(NV - 1), $urandom_range(NV - 1));
               default: ;
            endcase
         end
      // shrink the graph now and then so stale entries get skipped
      if ($urandom_range(9) == 0 && n > 1)
         write_vertex_count(CSR_W'($urandom_range(1, n - 1)));
      if ($urandom_range(19) != 0)
         send_op(OP_RUN, $urandom_range(NV - 1), $urandom_range(NV - 1));
      nreads = $urandom_range(1, 16);
      for (int unsigned i = 0; i < nreads; i++)
         send_op(OP_READ,
                 ($urandom_range(99) < 85) ? $urandom_range(n_vertices - 1)
                                           : $urandom_range(NV - 1),
                 $urandom_range(NV - 1));
   endtask

   initial begin
      int start_reqs, phase_no;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      cur_typed   = 1'b0;
      idle_on     = 1'b1;
      errors = 0; cycles = 0; reqs_sent = 0;
      runs_done = 0; reads_ok = 0; full_hits = 0;
      n_vertices = 1; n_loaded = 0; last_v = 0; cores_valid = 1'b0;
      first_entry[0] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR)
            write_vertex_count(dir_rows[i].csr_val);
         else begin
            cur_typed = dir_rows[i].typed;
            cur_typed_rsp.vertex_echo = dir_rows[i].v;
            cur_typed_rsp.core_number = dir_rows[i].core;
            cur_typed_rsp.status      = dir_rows[i].st;
            send_op(dir_rows[i].op, dir_rows[i].v, dir_rows[i].nb);
         end
      end

      start_reqs = reqs_sent;
      phase_no = 0;
      while (reqs_sent - start_reqs < RAND_REQS) begin
         graph_phase(phase_no);
         phase_no++;
      end

      wait_drained();
      repeat (50) @(posedge clock);
      $display("Sent %0d requests over %0d graph phases, %0d decompositions run.",
               reqs_sent, phase_no, runs_done);
      $display("Nonzero core reads: %0d, store-full responses: %0d, mismatches: %0d.",
               reads_ok, full_hits, errors);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
